// File: hdl/xcfr_pkg.sv
// Shared constants, result codes and control interface types for the frame receiver.
`default_nettype none

package xcfr_pkg;

    localparam int MAX_PAYLOAD = 28;
    localparam int IDX_W       = $clog2(MAX_PAYLOAD);

    localparam logic [7:0] HDR_BYTE      = 8'h3D;
    localparam logic [7:0] PARTNER_ACK   = 8'hC5;
    localparam logic [7:0] ID_NONE       = 8'hFF;
    localparam logic [7:0] TIMEOUT_RESET = 8'd10;
    localparam logic [7:0] MAX_LEN_BYTE  = 8'(MAX_PAYLOAD);

    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    typedef enum logic [2:0] {
        KIND_SEND_ACK  = 3'd0,
        KIND_PAYLOAD   = 3'd1,
        KIND_PARTNER   = 3'd2,
        KIND_BAD_SUM   = 3'd3,
        KIND_TIMEOUT   = 3'd4,
        KIND_TOO_LONG  = 3'd5
    } kind_t;

    // controller -> datapath
    typedef struct packed {
        logic take;       // input transfer this cycle
        logic cfg_we;     // timeout register write
        logic load_pend;  // move pending result into the output register
        logic load_dump;  // move next payload byte into the output register
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic has_result;
        logic has_dump;
        logic dump_last;
    } dp_status_t;

endpackage

`default_nettype wire

// File: hdl/xcfr_datapath.sv
// Deframing datapath: frame phase, checksum, payload store, pending and output registers.
`default_nettype none

module xcfr_datapath (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire xcfr_pkg::ctrl_cmd_t     cmd,
    input  wire logic                    func,
    input  wire logic [7:0]              rx_byte,
    input  wire logic [7:0]              cfg_data,
    output xcfr_pkg::dp_status_t         status,
    output logic [2:0]                   kind,
    output logic [7:0]                   data_byte,
    output logic [7:0]                   frame_number,
    output logic                         last
);

    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_ID    = 5'b00010,
        PH_LEN   = 5'b00100,
        PH_DATA  = 5'b01000,
        PH_CHECK = 5'b10000
    } phase_t;

    phase_t                       phase_reg, phase_next;
    logic [7:0]                   tmo_reg;
    logic [7:0]                   cur_id_reg, cur_id_next;
    logic [7:0]                   len_reg, len_next;
    logic [xcfr_pkg::IDX_W-1:0]   taken_reg, taken_next, taken_inc;
    logic [7:0]                   xor_reg, xor_next;
    logic [7:0]                   wait_reg, wait_next;
    logic [7:0]                   last_id_reg, last_id_next;
    logic [7:0]                   store_mem [xcfr_pkg::MAX_PAYLOAD];
    logic                         store_we;

    logic                         res_valid, res_dump;
    xcfr_pkg::kind_t              res_kind;
    logic [7:0]                   res_frame;

    logic                         has_result_reg, has_dump_reg;
    xcfr_pkg::kind_t              pend_kind_reg;
    logic [7:0]                   pend_frame_reg;
    logic [xcfr_pkg::IDX_W-1:0]   dump_idx_reg;

    xcfr_pkg::kind_t              out_kind_reg;
    logic [7:0]                   out_data_reg, out_frame_reg;
    logic                         out_last_reg;

    assign taken_inc = taken_reg + 1'b1;

    always_comb
    begin
        phase_next   = phase_reg;
        cur_id_next  = cur_id_reg;
        len_next     = len_reg;
        taken_next   = taken_reg;
        xor_next     = xor_reg;
        wait_next    = wait_reg;
        last_id_next = last_id_reg;
        store_we     = 1'b0;
        res_valid    = 1'b0;
        res_dump     = 1'b0;
        res_kind     = xcfr_pkg::KIND_SEND_ACK;
        res_frame    = cur_id_reg;
        if (cmd.take)
        begin
            if (func == xcfr_pkg::FUNC_TICK)
            begin
                if (phase_reg != PH_IDLE)
                begin
                    if (wait_reg <= 8'd1)
                    begin
                        res_valid  = 1'b1;
                        res_kind   = xcfr_pkg::KIND_TIMEOUT;
                        res_frame  = (phase_reg == PH_ID) ? 8'd0 : cur_id_reg;
                        phase_next = PH_IDLE;
                        wait_next  = 8'd0;
                    end
                    else
                    begin
                        wait_next = wait_reg - 8'd1;
                    end
                end
            end
            else
            begin
                case (phase_reg)
                    PH_ID:
                    begin
                        cur_id_next = rx_byte;
                        xor_next    = xor_reg ^ rx_byte;
                        wait_next   = tmo_reg;
                        phase_next  = PH_LEN;
                    end
                    PH_LEN:
                    begin
                        if (rx_byte > xcfr_pkg::MAX_LEN_BYTE)
                        begin
                            res_valid  = 1'b1;
                            res_kind   = xcfr_pkg::KIND_TOO_LONG;
                            phase_next = PH_IDLE;
                            wait_next  = 8'd0;
                        end
                        else
                        begin
                            len_next   = rx_byte;
                            taken_next = '0;
                            xor_next   = xor_reg ^ rx_byte;
                            wait_next  = tmo_reg;
                            phase_next = (rx_byte == 8'd0) ? PH_CHECK : PH_DATA;
                        end
                    end
                    PH_DATA:
                    begin
                        store_we   = 1'b1;
                        taken_next = taken_inc;
                        xor_next   = xor_reg ^ rx_byte;
                        wait_next  = tmo_reg;
                        if (8'(taken_inc) >= len_reg)
                            phase_next = PH_CHECK;
                    end
                    PH_CHECK:
                    begin
                        phase_next = PH_IDLE;
                        wait_next  = 8'd0;
                        res_valid  = 1'b1;
                        if (rx_byte != xor_reg)
                        begin
                            res_kind = xcfr_pkg::KIND_BAD_SUM;
                        end
                        else
                        begin
                            res_kind = xcfr_pkg::KIND_SEND_ACK;
                            if (cur_id_reg != last_id_reg)
                            begin
                                last_id_next = cur_id_reg;
                                res_dump     = (len_reg != 8'd0);
                            end
                        end
                    end
                    default:
                    begin
                        // idle: partner ack or start of a frame, other bytes dropped
                        phase_next = PH_IDLE;
                        if (rx_byte == xcfr_pkg::PARTNER_ACK)
                        begin
                            res_valid = 1'b1;
                            res_kind  = xcfr_pkg::KIND_PARTNER;
                            res_frame = 8'd0;
                        end
                        else if (rx_byte == xcfr_pkg::HDR_BYTE)
                        begin
                            xor_next   = xcfr_pkg::HDR_BYTE;
                            wait_next  = tmo_reg;
                            phase_next = PH_ID;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            tmo_reg        <= xcfr_pkg::TIMEOUT_RESET;
            cur_id_reg     <= 8'd0;
            len_reg        <= 8'd0;
            taken_reg      <= '0;
            xor_reg        <= 8'd0;
            wait_reg       <= 8'd0;
            last_id_reg    <= xcfr_pkg::ID_NONE;
            has_result_reg <= 1'b0;
            has_dump_reg   <= 1'b0;
            dump_idx_reg   <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            cur_id_reg  <= cur_id_next;
            len_reg     <= len_next;
            taken_reg   <= taken_next;
            xor_reg     <= xor_next;
            wait_reg    <= wait_next;
            last_id_reg <= last_id_next;
            if (cmd.cfg_we)
                tmo_reg <= cfg_data;
            if (cmd.take)
            begin
                has_result_reg <= res_valid;
                has_dump_reg   <= res_dump;
            end
            if (cmd.load_pend)
                dump_idx_reg <= '0;
            else if (cmd.load_dump)
                dump_idx_reg <= dump_idx_reg + 1'b1;
        end
    end

    // payload store and result registers carry no reset
    always_ff @(posedge clk)
    begin
        if (store_we)
            store_mem[taken_reg] <= rx_byte;
        if (cmd.take)
        begin
            pend_kind_reg  <= res_kind;
            pend_frame_reg <= res_frame;
        end
        if (cmd.load_pend)
        begin
            out_kind_reg  <= pend_kind_reg;
            out_data_reg  <= 8'd0;
            out_frame_reg <= pend_frame_reg;
            out_last_reg  <= !has_dump_reg;
        end
        else if (cmd.load_dump)
        begin
            out_kind_reg  <= xcfr_pkg::KIND_PAYLOAD;
            out_data_reg  <= store_mem[dump_idx_reg];
            out_frame_reg <= cur_id_reg;
            out_last_reg  <= status.dump_last;
        end
    end

    assign status.has_result = has_result_reg;
    assign status.has_dump   = has_dump_reg;
    assign status.dump_last  = (8'(dump_idx_reg) + 8'd1 == len_reg);

    assign kind         = out_kind_reg;
    assign data_byte    = out_data_reg;
    assign frame_number = out_frame_reg;
    assign last         = out_last_reg;

endmodule

`default_nettype wire

// File: hdl/xcfr_controller.sv
// Handshake sequencer: input transfers, result delivery and payload burst control.
`default_nettype none

module xcfr_controller (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  out_stall,
    input  wire logic                  cfg_valid,
    input  wire xcfr_pkg::dp_status_t  status,
    output xcfr_pkg::ctrl_cmd_t        cmd,
    output logic                       in_stall,
    output logic                       out_valid,
    output logic                       cfg_ready
);

    typedef enum logic [2:0] {
        ST_WAIT_IN = 3'b001,
        ST_SEND    = 3'b010,
        ST_DUMP    = 3'b100
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        slot_free;

    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next    = state_reg;
        cmd.take      = 1'b0;
        cmd.cfg_we    = cfg_valid;
        cmd.load_pend = 1'b0;
        cmd.load_dump = 1'b0;
        case (state_reg)
            ST_SEND:
            begin
                if (!status.has_result)
                begin
                    state_next = ST_WAIT_IN;
                end
                else if (slot_free)
                begin
                    cmd.load_pend = 1'b1;
                    state_next    = status.has_dump ? ST_DUMP : ST_WAIT_IN;
                end
            end
            ST_DUMP:
            begin
                if (slot_free)
                begin
                    cmd.load_dump = 1'b1;
                    if (status.dump_last)
                        state_next = ST_WAIT_IN;
                end
            end
            default:
            begin
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = ST_SEND;
                end
            end
        endcase
        out_valid_next = cmd.load_pend || cmd.load_dump || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_WAIT_IN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_WAIT_IN);
    assign out_valid = out_valid_reg;
    assign cfg_ready = 1'b1;

endmodule

`default_nettype wire

// File: hdl/xor_checked_frame_receiver.sv
// Top level of the XOR-checked serial frame receiver.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------------------
//  in      | sink      | in_valid / in_stall | func, rx_byte
//  out     | source    | out_valid/out_stall | kind, data_byte, frame_number, last
//  cfg     | sink      | cfg_valid/cfg_ready | cfg_data (byte_timeout_ticks)
//
//  An input transfer is taken in ST_WAIT_IN and resolved in ST_SEND; a new frame with L
//  payload bytes then sends them from the store, one per cycle while the output is free.
//  A result waits in the output register, so the next input transfer is taken
//  while it is still stalled; further results wait on out_stall.
//  Reset clears the frame phase, timeout register (to 10) and last id (to 0xFF);
//  the payload store is not cleared and is only read after being written.
`default_nettype none

module xor_checked_frame_receiver (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // input channel
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic       func,
    input  wire logic [7:0] rx_byte,
    // result channel
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [2:0]      kind,
    output logic [7:0]      data_byte,
    output logic [7:0]      frame_number,
    output logic            last,
    // timeout register write channel
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] cfg_data
);

    xcfr_pkg::ctrl_cmd_t  cmd;
    xcfr_pkg::dp_status_t status;

    // Sequence transfers: take an item, hand its result to the output register,
    // then stream the buffered payload when the frame carries a new id.
    xcfr_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .cfg_valid (cfg_valid),
        .status    (status),
        .cmd       (cmd),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cfg_ready (cfg_ready)
    );

    // Track the frame phase, running checksum and byte timer; hold the payload.
    xcfr_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .func         (func),
        .rx_byte      (rx_byte),
        .cfg_data     (cfg_data),
        .status       (status),
        .kind         (kind),
        .data_byte    (data_byte),
        .frame_number (frame_number),
        .last         (last)
    );

endmodule

`default_nettype wire

// File: hdl/xcfr_checker.sv
// Port-level checker for the frame receiver, bound to the top level.
`default_nettype none

module xcfr_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_stall,
    input  wire logic       out_valid,
    input  wire logic       out_stall,
    input  wire logic [2:0] kind,
    input  wire logic [7:0] data_byte,
    input  wire logic [7:0] frame_number,
    input  wire logic       last
);

    // a held result keeps its contents
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(data_byte)
            && $stable(frame_number) && $stable(last))
        else $error("stalled result changed");

    // every taken transfer raises the stall in the cycle after it, while it resolves
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken on back-to-back cycles");

    // only payload results carry data
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != xcfr_pkg::KIND_PAYLOAD) |-> data_byte == 8'd0)
        else $error("data on a non-payload result");

    // a partner ack stands alone with no frame number
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == xcfr_pkg::KIND_PARTNER) |-> frame_number == 8'd0 && last)
        else $error("malformed partner ack");

    // a payload byte never closes the burst of another frame
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> !out_valid
            || (kind == xcfr_pkg::KIND_PAYLOAD && frame_number == $past(frame_number)))
        else $error("burst interrupted");

endmodule

bind xor_checked_frame_receiver xcfr_checker u_xcfr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .data_byte    (data_byte),
    .frame_number (frame_number),
    .last         (last)
);

`default_nettype wire

// File: dv/tb_top.sv
// Self-checking testbench for the XOR-checked serial frame receiver.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Cycles to let the block drain a payload burst before touching the register.
    localparam int SETTLE_CYCLES = 40;
    // Cycles without any transfer on any channel before the run is declared hung.
    localparam int QUIET_LIMIT   = 2000;
    // Frame-relevant input transfers per random phase.
    localparam int PHASE_ITEMS   = 18;
    localparam int DIR_ROWS      = 29;
    localparam int REPORT_LIMIT  = 10;

    typedef enum logic [4:0] {
        RX_IDLE  = 5'b00001,
        RX_ID    = 5'b00010,
        RX_LEN   = 5'b00100,
        RX_DATA  = 5'b01000,
        RX_CHECK = 5'b10000
    } rx_phase_t;

    typedef enum logic [1:0] {
        ROW_BYTE,
        ROW_TICK,
        ROW_CFG
    } row_op_t;

    typedef struct packed {
        xcfr_pkg::kind_t kind;
        logic [7:0]      data;
        logic [7:0]      frame;
        logic            last;
    } result_t;

    // One line of the directed table; a typed row carries its single result.
    typedef struct packed {
        row_op_t         op;
        logic [7:0]      val;
        logic            typed;
        xcfr_pkg::kind_t kind;
        logic [7:0]      frame;
    } row_t;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       in_valid     = 1'b0;
    logic       in_stall;
    logic       func         = xcfr_pkg::FUNC_BYTE;
    logic [7:0] rx_byte      = 8'h00;
    logic       out_valid;
    logic       out_stall    = 1'b0;
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic [7:0] frame_number;
    logic       last;
    logic       cfg_valid    = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data     = 8'h00;

    xor_checked_frame_receiver dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .data_byte    (data_byte),
        .frame_number (frame_number),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Deframer mirror: tracks the receiver state and predicts its results.
    // ------------------------------------------------------------------
    rx_phase_t  fr_phase   = RX_IDLE;
    logic [7:0] fr_id      = 8'h00;
    logic [7:0] fr_len     = 8'h00;
    int         fr_taken   = 0;
    logic [7:0] fr_xor     = 8'h00;
    logic [7:0] fr_wait    = 8'h00;
    logic [7:0] fr_last_id = xcfr_pkg::ID_NONE;
    logic [7:0] fr_timeout = xcfr_pkg::TIMEOUT_RESET;
    logic [7:0] fr_store [xcfr_pkg::MAX_PAYLOAD];

    result_t step_results[$];   // results of the transfer just taken
    result_t due_results[$];    // results still to come out of the block

    int  mismatch_count = 0;
    int  counted_items  = 0;
    int  quiet_cycles   = 0;
    bit  steady_flow    = 1'b0;
    int  stall_run      = 0;
    int  stall_roll;
    result_t got;
    result_t want;
    row_t       directed_rows [DIR_ROWS];
    logic [7:0] phase_timeouts [5];

    function automatic void emit(xcfr_pkg::kind_t k, logic [7:0] d, logic [7:0] fn);
        step_results.push_back('{kind: k, data: d, frame: fn, last: 1'b0});
    endfunction

    // Fold a frame byte into the checksum and rearm the byte timer.
    function automatic void absorb(logic [7:0] b);
        fr_xor  = fr_xor ^ b;
        fr_wait = fr_timeout;
    endfunction

    // Advance the mirror by one input transfer; touched is low when the
    // transfer is simply ignored by an idle receiver.
    task automatic deframe_step(input logic f, input logic [7:0] b, output bit touched);
        touched = 1'b1;
        step_results.delete();
        if (f == xcfr_pkg::FUNC_TICK)
        begin
            if (fr_phase == RX_IDLE)
                touched = 1'b0;
            else if (fr_wait <= 8'd1)
            begin
                // no id yet means no frame number to report
                emit(xcfr_pkg::KIND_TIMEOUT, 8'h00, (fr_phase == RX_ID) ? 8'h00 : fr_id);
                fr_phase = RX_IDLE;
                fr_wait  = 8'h00;
            end
            else
                fr_wait = fr_wait - 8'd1;
        end
        else
        begin
            case (fr_phase)
                RX_IDLE:
                begin
                    if (b == xcfr_pkg::PARTNER_ACK)
                        emit(xcfr_pkg::KIND_PARTNER, 8'h00, 8'h00);
                    else if (b == xcfr_pkg::HDR_BYTE)
                    begin
                        fr_xor = 8'h00;
                        absorb(b);
                        fr_phase = RX_ID;
                    end
                    else
                        touched = 1'b0;
                end
                RX_ID:
                begin
                    fr_id = b;
                    absorb(b);
                    fr_phase = RX_LEN;
                end
                RX_LEN:
                begin
                    if (b > xcfr_pkg::MAX_LEN_BYTE)
                    begin
                        emit(xcfr_pkg::KIND_TOO_LONG, 8'h00, fr_id);
                        fr_phase = RX_IDLE;
                        fr_wait  = 8'h00;
                    end
                    else
                    begin
                        fr_len   = b;
                        fr_taken = 0;
                        absorb(b);
                        fr_phase = (b == 8'h00) ? RX_CHECK : RX_DATA;
                    end
                end
                RX_DATA:
                begin
                    if (fr_taken < xcfr_pkg::MAX_PAYLOAD)
                        fr_store[fr_taken] = b;
                    fr_taken++;
                    absorb(b);
                    if (fr_taken >= int'(fr_len))
                        fr_phase = RX_CHECK;
                end
                default:
                begin
                    fr_phase = RX_IDLE;
                    fr_wait  = 8'h00;
                    if (b != fr_xor)
                        emit(xcfr_pkg::KIND_BAD_SUM, 8'h00, fr_id);
                    else
                    begin
                        emit(xcfr_pkg::KIND_SEND_ACK, 8'h00, fr_id);
                        // a repeated id is only acknowledged
                        if (fr_id != fr_last_id)
                        begin
                            fr_last_id = fr_id;
                            for (int i = 0; i < int'(fr_len) && i < xcfr_pkg::MAX_PAYLOAD; i++)
                                emit(xcfr_pkg::KIND_PAYLOAD, fr_store[i], fr_id);
                        end
                    end
                end
            endcase
        end
        if (step_results.size() > 0)
            step_results[step_results.size() - 1].last = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    // Mostly back to back, some short gaps, a few long ones.
    function automatic int sender_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady_flow || roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Drop valid between transfers when n is positive; the next transfer raises it again.
    task automatic pause_sender(input int n);
        if (n > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // Present one input transfer, wait for it to be taken, then queue what it
    // should produce: the typed result if given, otherwise the prediction.
    task automatic send_rx(input logic f, input logic [7:0] b,
                           input logic typed = 1'b0, input result_t typed_res = '0);
        bit touched;
        pause_sender(sender_gap());
        @(negedge clk);
        in_valid <= 1'b1;
        func     <= f;
        rx_byte  <= b;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        deframe_step(f, b, touched);
        if (touched)
            counted_items++;
        if (typed)
            due_results.push_back(typed_res);
        else
            foreach (step_results[i])
                due_results.push_back(step_results[i]);
    endtask

    // Hold the sender until every result is out and the block has settled,
    // then write the byte timeout register.
    task automatic write_timeout(input logic [7:0] v);
        @(negedge clk);
        in_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        fr_timeout = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // A frame with random content: id often repeated, short lengths mostly,
    // now and then the maximum or an oversize length, a bad checksum, tick
    // runs between bytes, a timer run-out, or a frame simply abandoned.
    task automatic send_frame();
        logic [7:0] seq[$];
        logic [7:0] id;
        logic [7:0] len;
        logic [7:0] sum;
        logic [7:0] b;
        int         roll;
        int         t;
        roll = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
            0:       id = fr_last_id;
            1:       id = xcfr_pkg::ID_NONE;
            default: id = 8'($urandom_range(0, 255));
        endcase
        if (roll < 6)
            len = 8'($urandom_range(xcfr_pkg::MAX_PAYLOAD + 1, 255));
        else if (roll < 12)
            len = xcfr_pkg::MAX_LEN_BYTE;
        else
            len = 8'($urandom_range(0, 6));
        sum = xcfr_pkg::HDR_BYTE ^ id ^ len;
        seq.push_back(xcfr_pkg::HDR_BYTE);
        seq.push_back(id);
        seq.push_back(len);
        if (len <= xcfr_pkg::MAX_LEN_BYTE)
        begin
            for (int k = 0; k < int'(len); k++)
            begin
                b = 8'($urandom_range(0, 255));
                seq.push_back(b);
                sum = sum ^ b;
            end
            if ($urandom_range(0, 9) == 0)
                sum = sum ^ 8'($urandom_range(1, 255));
            seq.push_back(sum);
        end
        foreach (seq[k])
        begin
            if (k > 0)
            begin
                t = int'(fr_timeout);
                if (t <= 16 && $urandom_range(0, 19) == 0)
                begin
                    // run the byte timer out
                    while (fr_phase != RX_IDLE)
                        send_rx(xcfr_pkg::FUNC_TICK, 8'($urandom_range(0, 255)));
                end
                else if (t >= 2 && $urandom_range(0, 2) == 0)
                    repeat ($urandom_range(1, (t > 4) ? 3 : t - 1))
                        send_rx(xcfr_pkg::FUNC_TICK, 8'($urandom_range(0, 255)));
            end
            send_rx(xcfr_pkg::FUNC_BYTE, seq[k]);
            // stop once the frame is over, or walk away from it now and then
            if (fr_phase == RX_IDLE || $urandom_range(0, 39) == 0)
                break;
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver side: random stall runs, mostly short, a few long.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n || steady_flow)
        begin
            out_stall <= 1'b0;
            stall_run <= 0;
        end
        else if (stall_run > 0)
            stall_run <= stall_run - 1;
        else
        begin
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 65)
            begin
                out_stall <= 1'b0;
                stall_run <= $urandom_range(0, 4);
            end
            else if (stall_roll < 95)
            begin
                out_stall <= 1'b1;
                stall_run <= $urandom_range(0, 2);
            end
            else
            begin
                out_stall <= 1'b1;
                stall_run <= $urandom_range(9, 29);
            end
        end
    end

    function automatic void log_fault(string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%s", msg);
    endfunction

    // Compare every result transfer with the oldest pending expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{kind: xcfr_pkg::kind_t'(kind), data: data_byte, frame: frame_number,
                    last: last};
            if (due_results.size() == 0)
                log_fault($sformatf("unexpected result: kind %0d data %02h frame %02h last %0d",
                                    got.kind, got.data, got.frame, got.last));
            else
            begin
                want = due_results.pop_front();
                if (got.kind !== want.kind || got.data !== want.data ||
                    got.frame !== want.frame || got.last !== want.last)
                    log_fault($sformatf({"result mismatch: expected kind %0d data %02h ",
                                         "frame %02h last %0d, got kind %0d data %02h ",
                                         "frame %02h last %0d"},
                                        want.kind, want.data, want.frame, want.last,
                                        got.kind, got.data, got.frame, got.last));
            end
        end
    end

    // Watchdog: any transfer on any channel restarts the count.
    initial
    begin : watchdog
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("tb_top failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        row_t r;

        // Directed part. Rows with a typed result hold what can be read off
        // the frame format directly; the rest go through the mirror.
        directed_rows = '{
            // partner ack while idle, then a stray byte and a tick: both ignored
            '{ROW_BYTE, 8'hC5, 1'b1, xcfr_pkg::KIND_PARTNER,  8'h00},
            '{ROW_BYTE, 8'h00, 1'b0, xcfr_pkg::KIND_SEND_ACK, 8'h00},
            '{ROW_TICK, 8'h00, 1'b0, xcfr_pkg::KIND_SEND_ACK, 8'h00},
            // zero-length frame, id 0: checksum right after the length
            '{ROW_BYTE, 8'h3D, 1'b0, xcfr_pkg::KIND_SEND_ACK, 8'h00},
            '{ROW_BYTE, 8'h00, 1'b0, xcfr_pkg::KIND_SEND_ACK, 8'h00},
            '{ROW_BYTE, 8'h00, 1'b0, xcfr_pkg::KIND_SEND_ACK, 8'h00},
            '{ROW_BYTE, 8'h3D, 1'b1, xcfr_pkg::KIND_SEND_ACK, 8'h00},
            // same id again: acknowledged only
            '{ROW_BYTE, 8'h3D, 1'b0, xcfr_pkg::KIND_SEND_ACK, 8'h00},
            '{ROW_BYTE, 8'h00, 1'b0, xcfr_pkg::KIND_SEND_ACK, 8'h00},
            '{ROW_BYTE, 8'h00, 1'b0, xcfr_pkg::KIND_SEND_ACK, 8'h00},
            '{ROW_BYTE, 8'h3D, 1'b1, xcfr_pkg::KIND_SEND_ACK, 8'h00},
            // header and partner-ack values inside a frame are plain bytes
            '{ROW_BYTE, 8'h3D, 1'b0, xcfr_pkg::KIND_SEND_ACK, 8'h00},
            '{ROW_BYTE, 8'h3D, 1'b0, xcfr_pkg::KIND_SEND_ACK, 8'h00},
            '{ROW_BYTE, 8'h01, 1'b0, xcfr_pkg::KIND_SEND_ACK, 8'h00},
            '{ROW_BYTE, 8'hC5, 1'b0, xcfr_pkg::KIND_SEND_ACK, 8'h00},
            '{ROW_BYTE, 8'hC4, 1'b0, xcfr_pkg::KIND_SEND_ACK, 8'h00},
            // length one above the buffer
            '{ROW_BYTE, 8'h3D, 1'b0, xcfr_pkg::KIND_SEND_ACK, 8'h00},
            '{ROW_BYTE, 8'h07, 1'b0, xcfr_pkg::KIND_SEND_ACK, 8'h00},
            '{ROW_BYTE, 8'h1D, 1'b1, xcfr_pkg::KIND_TOO_LONG, 8'h07},
            // wrong checksum
            '{ROW_BYTE, 8'h3D, 1'b0, xcfr_pkg::KIND_SEND_ACK, 8'h00},
            '{ROW_BYTE, 8'h08, 1'b0, xcfr_pkg::KIND_SEND_ACK, 8'h00},
            '{ROW_BYTE, 8'h00, 1'b0, xcfr_pkg::KIND_SEND_ACK, 8'h00},
            '{ROW_BYTE, 8'hFF, 1'b1, xcfr_pkg::KIND_BAD_SUM,  8'h08},
            // timeout register zero: first tick times out, before and after the id
            '{ROW_CFG,  8'h00, 1'b0, xcfr_pkg::KIND_SEND_ACK, 8'h00},
            '{ROW_BYTE, 8'h3D, 1'b0, xcfr_pkg::KIND_SEND_ACK, 8'h00},
            '{ROW_TICK, 8'hFF, 1'b1, xcfr_pkg::KIND_TIMEOUT,  8'h00},
            '{ROW_BYTE, 8'h3D, 1'b0, xcfr_pkg::KIND_SEND_ACK, 8'h00},
            '{ROW_BYTE, 8'h09, 1'b0, xcfr_pkg::KIND_SEND_ACK, 8'h00},
            '{ROW_TICK, 8'h00, 1'b1, xcfr_pkg::KIND_TIMEOUT,  8'h09}
        };
        phase_timeouts = '{8'd255, 8'd1, 8'($urandom_range(2, 16)), 8'd3,
                           xcfr_pkg::TIMEOUT_RESET};

        // Hold reset, then release it between clock edges.
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            r = directed_rows[i];
            if (r.op == ROW_CFG)
                write_timeout(r.val);
            else
                send_rx((r.op == ROW_TICK) ? xcfr_pkg::FUNC_TICK : xcfr_pkg::FUNC_BYTE,
                        r.val, r.typed,
                        '{kind: r.kind, data: 8'h00, frame: r.frame, last: 1'b1});
        end

        // Random part, one phase per timeout setting; the fourth runs with
        // neither side idling.
        foreach (phase_timeouts[p])
        begin
            write_timeout(phase_timeouts[p]);
            steady_flow   = (p == 3);
            counted_items = 0;
            while (counted_items < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 3) != 0)
                    send_frame();
                else
                    case ($urandom_range(0, 2))
                        0:       send_rx(xcfr_pkg::FUNC_BYTE, xcfr_pkg::PARTNER_ACK);
                        1:       send_rx(xcfr_pkg::FUNC_BYTE, 8'($urandom_range(0, 255)));
                        default: send_rx(xcfr_pkg::FUNC_TICK, 8'($urandom_range(0, 255)));
                    endcase
            end
        end
        steady_flow = 1'b0;

        // Drain: wait for every expected result, then give the block time to
        // show anything extra.
        @(negedge clk);
        in_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
